@@ rtl/backlash_move_sequencer_core_macros.svh @@
// Assertion macros for the backlash move sequencer core.
// Expect signals named aclk and aresetn in the module that uses them.
`ifndef BACKLASH_MOVE_SEQUENCER_CORE_MACROS_SVH
`define BACKLASH_MOVE_SEQUENCER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define BMS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BMS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BMS_ASSERT_IMP(lbl, ante, cons, msg)
`define BMS_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/bms_pkg.sv @@
// Types, codes and helper functions for the backlash move sequencer.
// Used by every module of the block; depends on nothing.
package bms_pkg;

    localparam int POS_W    = 32;
    localparam int BL_W     = 24;
    localparam int DB_W     = 16;
    localparam int TOL_W    = 16;
    localparam int POLL_W   = 10;
    localparam int CFG_W    = 24;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 40;

    localparam logic [POLL_W-1:0] POLL_MAX = '1;

    // configuration register indexes
    localparam logic [1:0] CFG_BACKLASH   = 2'd0;
    localparam logic [1:0] CFG_DEADBAND   = 2'd1;
    localparam logic [1:0] CFG_DIVERGE    = 2'd2;
    localparam logic [1:0] CFG_POLL_LIMIT = 2'd3;

    localparam logic signed [BL_W-1:0] BACKLASH_RST   = -24'sd24000;
    localparam logic [DB_W-1:0]        DEADBAND_RST   = 16'd10;
    localparam logic [TOL_W-1:0]       DIVERGE_RST    = 16'd10;
    localparam logic [POLL_W-1:0]      POLL_LIMIT_RST = 10'd100;

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ABS  = 2'd1,
        PH_REL  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_POS  = 2'd1,
        DIR_NEG  = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_REL  = 2'd1,
        ACT_ABS  = 2'd2,
        ACT_STOP = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        OC_PENDING = 2'd0,
        OC_OK      = 2'd1,
        OC_FAIL    = 2'd2,
        OC_REFUSED = 2'd3
    } outcome_t;

    typedef enum logic [3:0] {
        K_REFUSED,
        K_IN_PLACE,
        K_REL_SHORT,
        K_ABS_START,
        K_IDLE_REPORT,
        K_FAIL_CLEAR,
        K_FAIL_KEEP,
        K_ABS_POLL,
        K_ABS_DONE,
        K_REL_POLL,
        K_REL_DONE
    } step_kind_t;

    typedef struct packed {
        logic signed [BL_W-1:0] backlash;
        logic [BL_W-1:0]        backlash_mag;
        logic                   backlash_pos;
        logic [DB_W-1:0]        deadband;
        logic [TOL_W-1:0]       diverge_tol;
        logic [POLL_W-1:0]      poll_limit;
    } cfg_t;

    typedef struct packed {
        logic                    is_report;
        logic signed [POS_W-1:0] target;
        logic signed [POS_W-1:0] reported;
        logic                    running;
        logic                    report_ok;
        logic signed [POS_W-1:0] goal;
    } item_t;

    // a - b with one guard bit, so it never wraps
    function automatic logic signed [POS_W:0] diff33(input logic signed [POS_W-1:0] a,
                                                     input logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] ax;
        logic signed [POS_W:0] bx;
        ax = {a[POS_W-1], a};
        bx = {b[POS_W-1], b};
        return ax - bx;
    endfunction

    function automatic logic [POS_W:0] mag33(input logic signed [POS_W:0] v);
        logic [POS_W:0] u;
        u = v;
        return v[POS_W] ? (~u + {{POS_W{1'b0}}, 1'b1}) : u;
    endfunction

endpackage

@@ rtl/bms_cfg_regs.sv @@
// Configuration register file of the backlash move sequencer.
// Depends on bms_pkg; derives backlash magnitude and sign for the datapath.
module bms_cfg_regs
    import bms_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    output cfg_t             cfg
);

    logic signed [BL_W-1:0] backlash_reg;
    logic [DB_W-1:0]        deadband_reg;
    logic [TOL_W-1:0]       diverge_reg;
    logic [POLL_W-1:0]      poll_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            backlash_reg   <= BACKLASH_RST;
            deadband_reg   <= DEADBAND_RST;
            diverge_reg    <= DIVERGE_RST;
            poll_limit_reg <= POLL_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BACKLASH:   backlash_reg   <= cfg_wdata[BL_W-1:0];
                CFG_DEADBAND:   deadband_reg   <= cfg_wdata[DB_W-1:0];
                CFG_DIVERGE:    diverge_reg    <= cfg_wdata[TOL_W-1:0];
                CFG_POLL_LIMIT: poll_limit_reg <= cfg_wdata[POLL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.backlash     = backlash_reg;
        cfg.backlash_mag = backlash_reg[BL_W-1] ? (~backlash_reg + {{(BL_W-1){1'b0}}, 1'b1})
                                                : backlash_reg;
        // zero backlash counts as a negative approach
        cfg.backlash_pos = !backlash_reg[BL_W-1] && (backlash_reg != '0);
        cfg.deadband     = deadband_reg;
        cfg.diverge_tol  = diverge_reg;
        cfg.poll_limit   = poll_limit_reg;
    end

endmodule

@@ rtl/bms_in_stage.sv @@
// Input register with skid entry; precomputes the saturated absolute goal.
// Depends on bms_pkg; feeds bms_step one item per cycle while item_ready is high.
module bms_in_stage
    import bms_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_W-1:0]    s_tdata,
    input  logic                   s_tuser,
    input  logic signed [BL_W-1:0] backlash,
    output logic                   item_valid,
    input  logic                   item_ready,
    output item_t                  item
);

    logic  main_valid_reg, main_valid_next;
    logic  skid_valid_reg, skid_valid_next;
    item_t main_reg;
    item_t skid_reg;
    item_t in_item;
    item_t main_src;
    logic  s_fire;
    logic  main_free;
    logic  load_main;
    logic  load_skid;
    logic signed [POS_W:0] goal_raw;

    always_comb begin
        goal_raw = diff33(s_tdata[31:0], {{(POS_W-BL_W){backlash[BL_W-1]}}, backlash});
        in_item.is_report = s_tuser;
        in_item.target    = s_tdata[31:0];
        in_item.reported  = s_tdata[63:32];
        in_item.running   = s_tdata[64];
        in_item.report_ok = s_tdata[65];
        // saturate target - backlash to the position range
        if (goal_raw[POS_W] != goal_raw[POS_W-1]) begin
            in_item.goal = goal_raw[POS_W] ? POS_MIN : POS_MAX;
        end else begin
            in_item.goal = goal_raw[POS_W-1:0];
        end
    end

    assign s_tready = !skid_valid_reg;
    assign s_fire   = s_tvalid && !skid_valid_reg;
    assign main_free = !main_valid_reg || item_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_main       = 1'b0;
        load_skid       = 1'b0;
        main_src        = in_item;
        if (main_free) begin
            if (skid_valid_reg) begin
                main_src        = skid_reg;
                load_main       = 1'b1;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                load_main       = s_fire;
                main_valid_next = s_fire;
            end
        end else begin
            // park the transaction while the main entry is held
            load_skid       = s_fire;
            skid_valid_next = skid_valid_reg || s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_main) begin
            main_reg <= main_src;
        end
        if (load_skid) begin
            skid_reg <= in_item;
        end
    end

    assign item_valid = main_valid_reg;
    assign item       = main_reg;

endmodule

@@ rtl/bms_step.sv @@
// Move sequencer state and decision logic with the result register.
// Depends on bms_pkg and the assertion macros header.
`include "backlash_move_sequencer_core_macros.svh"
module bms_step
    import bms_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                item_valid,
    output logic                item_ready,
    input  item_t               item,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [1:0]          m_tuser
);

    phase_t                  phase_reg, phase_next;
    dir_t                    dir_reg, dir_next;
    logic [POLL_W-1:0]       poll_reg, poll_next;
    logic signed [POS_W-1:0] cur_reg, cur_next;
    logic signed [POS_W-1:0] goal_reg, goal_next;
    logic [POS_W-1:0]        gap_reg, gap_next;

    logic                    m_valid_reg, m_valid_next;
    action_t                 action_reg, action_next;
    logic signed [POS_W-1:0] steps_reg, steps_next;
    outcome_t                outcome_reg, outcome_next;

    logic                    advance;
    logic                    busy;
    step_kind_t              kind;
    logic signed [POS_W:0]   delta;
    logic [POS_W:0]          delta_mag;
    logic                    in_band;
    logic                    dir_match;
    logic                    short_move;
    logic [POS_W:0]          gap_full;
    logic [POS_W-1:0]        gap_now;
    logic [POS_W:0]          start_gap_full;
    logic                    diverged;
    logic [POLL_W-1:0]       poll_inc;
    logic                    timed_out;
    dir_t                    rel_dir;

    assign item_ready = !m_valid_reg || m_tready;
    assign advance    = item_valid && item_ready;
    assign busy       = (phase_reg == PH_ABS) || (phase_reg == PH_REL);

    // decision datapath
    always_comb begin
        delta          = diff33(item.target, cur_reg);
        delta_mag      = mag33(delta);
        in_band        = delta_mag < {{(POS_W+1-DB_W){1'b0}}, cfg.deadband};
        dir_match      = (dir_reg != DIR_NONE) &&
                         ((dir_reg == DIR_POS) == (!delta[POS_W] && (delta != '0)));
        short_move     = delta_mag < {{(POS_W+1-BL_W){1'b0}}, cfg.backlash_mag};
        gap_full       = mag33(diff33(goal_reg, item.reported));
        gap_now        = gap_full[POS_W-1:0];
        start_gap_full = mag33(diff33(item.goal, cur_reg));
        diverged       = (poll_reg != '0) && (gap_now > gap_reg) &&
                         (gap_now > {{(POS_W-TOL_W){1'b0}}, cfg.diverge_tol});
        poll_inc       = (poll_reg == POLL_MAX) ? poll_reg : poll_reg + {{(POLL_W-1){1'b0}}, 1'b1};
        timed_out      = poll_inc >= cfg.poll_limit;
        rel_dir        = cfg.backlash_pos ? DIR_POS : DIR_NEG;
    end

    // classify the transaction
    always_comb begin
        if (!item.is_report) begin
            priority if (busy)                    kind = K_REFUSED;
            else if (in_band)                     kind = K_IN_PLACE;
            else if (dir_match && short_move)     kind = K_REL_SHORT;
            else                                  kind = K_ABS_START;
        end else begin
            priority if (!busy)                   kind = K_IDLE_REPORT;
            else if (!item.report_ok)             kind = (phase_reg == PH_ABS) ? K_FAIL_CLEAR
                                                                              : K_FAIL_KEEP;
            else if (phase_reg == PH_ABS) begin
                priority if (diverged)            kind = K_FAIL_CLEAR;
                else if (item.running)            kind = K_ABS_POLL;
                else                              kind = K_ABS_DONE;
            end else begin
                priority if (!item.running)       kind = K_REL_DONE;
                else if (timed_out)               kind = K_FAIL_KEEP;
                else                              kind = K_REL_POLL;
            end
        end
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        dir_next   = dir_reg;
        poll_next  = poll_reg;
        cur_next   = cur_reg;
        goal_next  = goal_reg;
        gap_next   = gap_reg;
        if (advance) begin
            if (item.is_report && item.report_ok) begin
                cur_next = item.reported;
            end
            unique case (kind)
                K_REFUSED: ;
                K_IN_PLACE:    phase_next = PH_IDLE;
                K_REL_SHORT: begin
                    phase_next = PH_REL;
                    poll_next  = '0;
                    dir_next   = rel_dir;
                end
                K_ABS_START: begin
                    phase_next = PH_ABS;
                    poll_next  = '0;
                    goal_next  = item.goal;
                    gap_next   = start_gap_full[POS_W-1:0];
                end
                K_IDLE_REPORT: ;
                K_FAIL_CLEAR: begin
                    phase_next = PH_IDLE;
                    poll_next  = '0;
                    dir_next   = DIR_NONE;
                end
                K_FAIL_KEEP, K_REL_DONE: begin
                    phase_next = PH_IDLE;
                    poll_next  = '0;
                end
                K_ABS_POLL: begin
                    poll_next = poll_inc;
                    if (poll_reg != '0) begin
                        gap_next = gap_now;
                    end
                end
                K_ABS_DONE: begin
                    if (poll_reg != '0) begin
                        gap_next = gap_now;
                    end
                    phase_next = PH_REL;
                    poll_next  = '0;
                    dir_next   = rel_dir;
                end
                K_REL_POLL:    poll_next = poll_inc;
                default: ;
            endcase
        end
    end

    // result
    always_comb begin
        action_next  = ACT_NONE;
        steps_next   = '0;
        outcome_next = OC_PENDING;
        unique case (kind)
            K_REFUSED:   outcome_next = OC_REFUSED;
            K_IN_PLACE,
            K_REL_DONE:  outcome_next = OC_OK;
            K_REL_SHORT: begin
                action_next = ACT_REL;
                steps_next  = delta[POS_W-1:0];
            end
            K_ABS_START: begin
                action_next = ACT_ABS;
                steps_next  = item.goal;
            end
            K_ABS_DONE: begin
                action_next = ACT_REL;
                steps_next  = {{(POS_W-BL_W){cfg.backlash[BL_W-1]}}, cfg.backlash};
            end
            K_FAIL_CLEAR,
            K_FAIL_KEEP: begin
                action_next  = ACT_STOP;
                outcome_next = OC_FAIL;
            end
            K_IDLE_REPORT, K_ABS_POLL, K_REL_POLL: ;
            default: ;
        endcase
        m_valid_next = advance || (m_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            dir_reg     <= DIR_NONE;
            poll_reg    <= '0;
            cur_reg     <= '0;
            goal_reg    <= '0;
            gap_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            dir_reg     <= dir_next;
            poll_reg    <= poll_next;
            cur_reg     <= cur_next;
            goal_reg    <= goal_next;
            gap_reg     <= gap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            action_reg  <= action_next;
            steps_reg   <= steps_next;
            outcome_reg <= outcome_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-POS_W-2){1'b0}}, outcome_reg, steps_reg};
    assign m_tuser  = action_reg;

    `BMS_ASSERT_IMP(a_rel_has_dir, phase_reg == PH_REL, dir_reg != DIR_NONE, "relative move without approach direction")
    `BMS_ASSERT_IMP(a_poll_only_busy, poll_reg != '0, busy, "poll count left over while idle")
    `BMS_ASSERT_IMP(a_stop_is_fail, m_valid_reg && action_reg == ACT_STOP, outcome_reg == OC_FAIL, "stop without failure")
    `BMS_ASSERT_NXT(a_refuse_keeps_state, advance && kind == K_REFUSED, $stable(phase_reg) && $stable(poll_reg), "refused request changed state")

endmodule

@@ rtl/backlash_move_sequencer_core.sv @@
// Backlash move sequencer core, top level.
// Accepted transactions pass the input register, one decision stage and the result register.
// One transaction per cycle is taken while m_tready does not stall the result register.
// s_tready is registered (skid entry), so a stalled result side costs no input cycle at once.
// Reset (aresetn low, synchronous): idle, no approach direction, positions and counts zero,
// configuration back to backlash -24000, deadband 10, tolerance 10, poll limit 100.
module backlash_move_sequencer_core
    import bms_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata,
    // request and status stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // target_steps, reported_position, motor_running,
                                          // report_ok, zero fill
    input  logic                s_tuser,  // opcode
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // move_steps, outcome, zero fill
    output logic [1:0]          m_tuser   // action
);

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  item_ready;

    bms_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bms_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .backlash   (cfg.backlash),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    bms_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule
